// ===== hw/rtl/piecewise_rolling_hash_digest_defines.svh =====
// Assertion macros used by the digest engine checker.
`ifndef PIECEWISE_ROLLING_HASH_DIGEST_DEFINES_SVH
`define PIECEWISE_ROLLING_HASH_DIGEST_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PRHD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("digest engine port check failed");

// Next-cycle implication, disabled while reset is high.
`define PRHD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("digest engine port check failed");

`endif

// ===== hw/rtl/prhd_pkg.sv =====
// Shared types, constants and functions of the piecewise rolling hash digest engine.
package prhd_pkg;

   localparam int DIGEST_LEN_DEFAULT = 64;
   localparam int WINDOW_LEN_DEFAULT = 9;

   localparam int HASH_W = 32;
   localparam int BYTE_W = 8;
   localparam int POS_W  = 8;
   localparam int SYM_W  = 7;
   localparam int BS_W   = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   localparam logic [HASH_W-1:0] PIECE_RELOAD = 32'h2802_1967;
   localparam logic [HASH_W-1:0] PIECE_PRIME  = 32'h0100_0193;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_FILTER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUAL_LANE     = 2'd2;

   // Pending result bits, emitted lowest first
   localparam int RES_TRIG0  = 0;
   localparam int RES_TRIG1  = 1;
   localparam int RES_FLUSH0 = 2;
   localparam int RES_FLUSH1 = 3;
   localparam int RES_N      = 4;

   typedef struct packed {
      logic accept;
      logic hash;
      logic roll;
      logic load_mask;
      logic emit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic keep;
      logic mod_busy;
      logic mask_empty;
   } status_type;

   // Whitespace and ASCII punctuation are not hashed.
   function automatic logic is_dropped(input logic [BYTE_W-1:0] b);
      logic d;
      d = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D) ||
          (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
          (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
      return d;
   endfunction

   function automatic logic [HASH_W-1:0] sext8(input logic [BYTE_W-1:0] b);
      return {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
   endfunction

   function automatic logic [HASH_W-1:0] piece_mix(input logic [HASH_W-1:0] c,
                                                   input logic [HASH_W-1:0] h);
      logic [HASH_W-1:0] x;
      x = h ^ c;
      return x * PIECE_PRIME;
   endfunction

   // Base64 alphabet: A-Z, a-z, 0-9, '+', '/'
   function automatic logic [SYM_W-1:0] b64_symbol(input logic [5:0] v);
      logic [SYM_W-1:0] s;
      logic [SYM_W-1:0] v7;
      v7 = {1'b0, v};
      priority if (v < 6'd26) begin
         s = 7'd65 + v7;
      end else if (v < 6'd52) begin
         s = 7'd71 + v7;
      end else if (v < 6'd62) begin
         s = v7 - 7'd4;
      end else if (v == 6'd62) begin
         s = 7'd43;
      end else begin
         s = 7'd47;
      end
      return s;
   endfunction

endpackage

// ===== hw/rtl/prhd_mod.sv =====
// Bit-serial remainder unit: one quotient bit per cycle over a 32-bit dividend.
module prhd_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [prhd_pkg::HASH_W-1:0] dividend,
   input  logic [prhd_pkg::HASH_W-1:0] divisor,
   output logic                        busy,
   output logic [prhd_pkg::HASH_W-1:0] remainder
);
   localparam int CountW = $clog2(prhd_pkg::HASH_W);

   logic                        busy_ff, busy_in;
   logic [CountW-1:0]           count_ff, count_in;
   logic [prhd_pkg::HASH_W-1:0] dvd_ff, dvd_in;
   logic [prhd_pkg::HASH_W-1:0] rem_ff, rem_in;
   logic [prhd_pkg::HASH_W:0]   shifted;
   logic [prhd_pkg::HASH_W:0]   dvs;

   assign shifted = {rem_ff, dvd_ff[prhd_pkg::HASH_W-1]};
   assign dvs     = {1'b0, divisor};

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         dvd_in   = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         dvd_in   = {dvd_ff[prhd_pkg::HASH_W-2:0], 1'b0};
         rem_in   = (shifted >= dvs) ? 32'(shifted - dvs) : shifted[prhd_pkg::HASH_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == CountW'(prhd_pkg::HASH_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;
endmodule

// ===== hw/rtl/prhd_datapath.sv =====
// Datapath: configuration, repeat filter, rolling hash, piece hashes and result register.
module prhd_datapath #(
   parameter int DIGEST_LEN = prhd_pkg::DIGEST_LEN_DEFAULT,
   parameter int WINDOW_LEN = prhd_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [prhd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [prhd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [prhd_pkg::BYTE_W-1:0]     req_byte_in,
   input  logic                            req_is_last,
   input  prhd_pkg::cmd_type               cmd,
   output prhd_pkg::status_type            status,
   output logic                            out_lane,
   output logic [prhd_pkg::POS_W-1:0]      out_position,
   output logic [prhd_pkg::SYM_W-1:0]      out_symbol,
   output logic                            out_end_of_run
);
   localparam int SlotW = $clog2(WINDOW_LEN);
   localparam int HW = prhd_pkg::HASH_W;
   localparam int BW = prhd_pkg::BYTE_W;
   localparam int PW = prhd_pkg::POS_W;
   localparam int RN = prhd_pkg::RES_N;

   // configuration
   logic [prhd_pkg::BS_W-1:0] block_size_ff;
   logic                      repeat_filter_ff;
   logic                      dual_lane_ff;

   // item being worked on
   logic [BW-1:0] byte_ff, byte_in;
   logic          last_ff, last_in;
   logic          keep_ff, keep_in;

   // hash state
   logic [BW-1:0]    prev_byte_ff, prev_byte_in;
   logic [1:0]       repeat_run_ff, repeat_run_in;
   logic [HW-1:0]    window_sum_ff, window_sum_in;
   logic [HW-1:0]    weighted_sum_ff, weighted_sum_in;
   logic [HW-1:0]    shift_hash_ff, shift_hash_in;
   logic [HW-1:0]    rolling_ff, rolling_in;
   logic [BW-1:0]    window_ff [WINDOW_LEN];
   logic [BW-1:0]    window_in [WINDOW_LEN];
   logic [SlotW-1:0] slot_ff, slot_in;
   logic [HW-1:0]    piece_ff [2];
   logic [HW-1:0]    piece_in [2];
   logic [PW-1:0]    pos_ff [2];
   logic [PW-1:0]    pos_in [2];
   logic [RN-1:0]    mask_ff, mask_in;

   // result register
   logic          lane_ff, lane_in;
   logic [PW-1:0] opos_ff, opos_in;
   logic [prhd_pkg::SYM_W-1:0] sym_ff, sym_in;
   logic          eor_ff, eor_in;

   // helpers
   logic [HW-1:0] c;
   logic [HW-1:0] leaving;
   logic [HW-1:0] roll_sum;
   logic [HW-1:0] bs0, bs1;
   logic [HW-1:0] rem0, rem1;
   logic          busy0, busy1;
   logic [1:0]    run_next;
   logic          trig0, trig1, flush;
   logic          sel_lane, sel_trig;
   logic [RN-1:0] rest;

   assign c        = prhd_pkg::sext8(byte_ff);
   assign leaving  = prhd_pkg::sext8(window_ff[slot_ff]);
   assign roll_sum = window_sum_ff + weighted_sum_ff + shift_hash_ff;
   assign bs0      = {1'b0, block_size_ff};
   assign bs1      = {block_size_ff, 1'b0};

   prhd_mod u_mod0 (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.roll),
      .dividend  (roll_sum),
      .divisor   (bs0),
      .busy      (busy0),
      .remainder (rem0)
   );

   prhd_mod u_mod1 (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.roll),
      .dividend  (roll_sum),
      .divisor   (bs1),
      .busy      (busy1),
      .remainder (rem1)
   );

   assign trig0 = keep_ff && (bs0 != '0) && (rem0 == bs0 - 32'd1);
   assign trig1 = keep_ff && dual_lane_ff && (bs1 != '0) && (rem1 == bs1 - 32'd1);
   assign flush = last_ff && (rolling_ff != '0);

   always_comb begin
      // pick the next pending result, lowest bit first
      priority if (mask_ff[prhd_pkg::RES_TRIG0]) begin
         sel_lane = 1'b0;
         sel_trig = 1'b1;
         rest     = mask_ff & 4'b1110;
      end else if (mask_ff[prhd_pkg::RES_TRIG1]) begin
         sel_lane = 1'b1;
         sel_trig = 1'b1;
         rest     = mask_ff & 4'b1100;
      end else if (mask_ff[prhd_pkg::RES_FLUSH0]) begin
         sel_lane = 1'b0;
         sel_trig = 1'b0;
         rest     = mask_ff & 4'b1000;
      end else begin
         sel_lane = 1'b1;
         sel_trig = 1'b0;
         rest     = '0;
      end
   end

   always_comb begin
      run_next = '0;
      if (req_byte_in == prev_byte_ff) begin
         run_next = (repeat_run_ff == 2'd3) ? 2'd3 : repeat_run_ff + 2'd1;
      end
   end

   always_comb begin
      byte_in         = byte_ff;
      last_in         = last_ff;
      keep_in         = keep_ff;
      prev_byte_in    = prev_byte_ff;
      repeat_run_in   = repeat_run_ff;
      window_sum_in   = window_sum_ff;
      weighted_sum_in = weighted_sum_ff;
      shift_hash_in   = shift_hash_ff;
      rolling_in      = rolling_ff;
      window_in       = window_ff;
      slot_in         = slot_ff;
      piece_in        = piece_ff;
      pos_in          = pos_ff;
      mask_in         = mask_ff;
      lane_in         = lane_ff;
      opos_in         = opos_ff;
      sym_in          = sym_ff;
      eor_in          = eor_ff;

      if (cmd.accept) begin
         byte_in       = req_byte_in;
         last_in       = req_is_last;
         prev_byte_in  = req_byte_in;
         repeat_run_in = run_next;
         keep_in       = !prhd_pkg::is_dropped(req_byte_in) &&
                         !(repeat_filter_ff && run_next == 2'd3);
      end

      if (cmd.hash && keep_ff) begin
         weighted_sum_in    = weighted_sum_ff - window_sum_ff + c * HW'(WINDOW_LEN);
         window_sum_in      = window_sum_ff + c - leaving;
         window_in[slot_ff] = byte_ff;
         slot_in            = (slot_ff == SlotW'(WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;
         shift_hash_in      = {shift_hash_ff[HW-6:0], 5'b0} ^ c;
         piece_in[0]        = prhd_pkg::piece_mix(c, piece_ff[0]);
         if (dual_lane_ff) begin
            piece_in[1] = prhd_pkg::piece_mix(c, piece_ff[1]);
         end
      end

      if (cmd.roll) begin
         rolling_in = roll_sum;
      end

      if (cmd.load_mask) begin
         mask_in = '0;
         mask_in[prhd_pkg::RES_TRIG0]  = trig0;
         mask_in[prhd_pkg::RES_TRIG1]  = trig1;
         mask_in[prhd_pkg::RES_FLUSH0] = flush;
         mask_in[prhd_pkg::RES_FLUSH1] = flush && dual_lane_ff;
      end

      if (cmd.emit) begin
         lane_in = sel_lane;
         opos_in = pos_ff[sel_lane];
         sym_in  = prhd_pkg::b64_symbol(piece_ff[sel_lane][5:0]);
         eor_in  = (rest == '0);
         mask_in = rest;
         if (sel_trig && pos_ff[sel_lane] < PW'(DIGEST_LEN - 2)) begin
            piece_in[sel_lane] = prhd_pkg::PIECE_RELOAD;
            pos_in[sel_lane]   = pos_ff[sel_lane] + 1'b1;
         end
      end

      // end of message: return the hash state to its reset values
      if (cmd.finish && last_ff) begin
         prev_byte_in    = '0;
         repeat_run_in   = '0;
         window_sum_in   = '0;
         weighted_sum_in = '0;
         shift_hash_in   = '0;
         rolling_in      = '0;
         slot_in         = '0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_in[i] = '0;
         end
         for (int l = 0; l < 2; l++) begin
            piece_in[l] = '0;
            pos_in[l]   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff    <= prhd_pkg::BS_W'(3);
         repeat_filter_ff <= 1'b1;
         dual_lane_ff     <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            prhd_pkg::CSR_BLOCK_SIZE:    block_size_ff    <= csr_wdata[prhd_pkg::BS_W-1:0];
            prhd_pkg::CSR_REPEAT_FILTER: repeat_filter_ff <= csr_wdata[0];
            prhd_pkg::CSR_DUAL_LANE:     dual_lane_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_byte_ff    <= '0;
         repeat_run_ff   <= '0;
         window_sum_ff   <= '0;
         weighted_sum_ff <= '0;
         shift_hash_ff   <= '0;
         rolling_ff      <= '0;
         slot_ff         <= '0;
         mask_ff         <= '0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
         for (int l = 0; l < 2; l++) begin
            piece_ff[l] <= '0;
            pos_ff[l]   <= '0;
         end
      end else begin
         prev_byte_ff    <= prev_byte_in;
         repeat_run_ff   <= repeat_run_in;
         window_sum_ff   <= window_sum_in;
         weighted_sum_ff <= weighted_sum_in;
         shift_hash_ff   <= shift_hash_in;
         rolling_ff      <= rolling_in;
         slot_ff         <= slot_in;
         mask_ff         <= mask_in;
         window_ff       <= window_in;
         piece_ff        <= piece_in;
         pos_ff          <= pos_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      keep_ff <= keep_in;
      lane_ff <= lane_in;
      opos_ff <= opos_in;
      sym_ff  <= sym_in;
      eor_ff  <= eor_in;
   end

   assign status.keep       = keep_ff;
   assign status.mod_busy   = busy0 || busy1;
   assign status.mask_empty = (mask_ff == '0);

   assign out_lane       = lane_ff;
   assign out_position   = opos_ff;
   assign out_symbol     = sym_ff;
   assign out_end_of_run = eor_ff;
endmodule

// ===== hw/rtl/prhd_ctrl.sv =====
// Controller: sequences each item through hash, remainder (kept bytes only) and result emission.
module prhd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  prhd_pkg::status_type status,
   output prhd_pkg::cmd_type    cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HASH = 3'd1;
   localparam logic [2:0] S_ROLL = 3'd2;
   localparam logic [2:0] S_MOD  = 3'd3;
   localparam logic [2:0] S_MASK = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash = 1'b1;
            state_in = status.keep ? S_ROLL : S_MASK;
         end
         S_ROLL: begin
            cmd.roll = 1'b1;
            state_in = S_MOD;
         end
         S_MOD: begin
            if (!status.mod_busy) begin
               state_in = S_MASK;
            end
         end
         S_MASK: begin
            cmd.load_mask = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (status.mask_empty) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else if (out_free) begin
               cmd.emit = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold the result until taken, load a new one when the register frees up
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== hw/rtl/piecewise_rolling_hash_digest.sv =====
// Top level of the piecewise rolling hash digest engine.
// Usage:
//   req_*  : one message byte per item, req_is_last marks the final byte.
//   rsp_*  : digest symbols (lane, position, base64 symbol); rsp_end_of_run
//            flags the last result caused by an input byte.
//   csr_*  : register writes (block size, repeat filter, dual lane), always
//            ready; write only while no byte is in flight.
// Sequencing: one byte at a time. A hashed byte passes the hash, roll,
//   remainder, mask and emit steps; the bit-serial remainder unit tests
//   the rolling hash against the block size. A dropped byte skips the roll
//   and remainder steps. At most four results per byte.
// Results go through a one-entry output register; if the receiver stalls,
//   the engine waits with the next result, and req_ready stays low until the
//   last result of the current byte is loaded.
// Reset (synchronous, active high) restores block size 3, repeat filter on,
//   single lane, and clears all hash state; the final byte of a message does
//   the same for the hash state after its flush.
module piecewise_rolling_hash_digest #(
   parameter int DIGEST_LEN = prhd_pkg::DIGEST_LEN_DEFAULT,
   parameter int WINDOW_LEN = prhd_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [prhd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [prhd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [prhd_pkg::BYTE_W-1:0]     req_byte_in,
   input  logic                            req_is_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_lane,
   output logic [prhd_pkg::POS_W-1:0]      rsp_position,
   output logic [prhd_pkg::SYM_W-1:0]      rsp_symbol,
   output logic                            rsp_end_of_run
);
   prhd_pkg::cmd_type    cmd;
   prhd_pkg::status_type status;

   assign csr_ready = 1'b1;

   prhd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   prhd_datapath #(
      .DIGEST_LEN (DIGEST_LEN),
      .WINDOW_LEN (WINDOW_LEN)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_byte_in    (req_byte_in),
      .req_is_last    (req_is_last),
      .cmd            (cmd),
      .status         (status),
      .out_lane       (rsp_lane),
      .out_position   (rsp_position),
      .out_symbol     (rsp_symbol),
      .out_end_of_run (rsp_end_of_run)
   );
endmodule

// ===== hw/rtl/prhd_checker.sv =====
// Port-level checks of the digest engine, bound to its top level.
`include "piecewise_rolling_hash_digest_defines.svh"

module prhd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_lane,
   input logic [prhd_pkg::POS_W-1:0]  rsp_position,
   input logic [prhd_pkg::SYM_W-1:0]  rsp_symbol,
   input logic                        rsp_end_of_run
);
   // a taken byte keeps req_ready low in the following cycle
   `PRHD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // a stalled result holds
   `PRHD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_symbol) && $stable(rsp_position) && $stable(rsp_lane) && $stable(rsp_end_of_run))

   // no new byte while results of the current one are still to come
   `PRHD_ASSERT_IMPL(a_no_accept_mid_run, clock, reset, rsp_valid && !rsp_end_of_run, !req_ready)

   // symbols come from the base64 alphabet
   `PRHD_ASSERT_IMPL(a_symbol_b64, clock, reset, rsp_valid, (rsp_symbol >= 7'd65 && rsp_symbol <= 7'd90) || (rsp_symbol >= 7'd97 && rsp_symbol <= 7'd122) || (rsp_symbol >= 7'd48 && rsp_symbol <= 7'd57) || rsp_symbol == 7'd43 || rsp_symbol == 7'd47)
endmodule

bind piecewise_rolling_hash_digest prhd_checker u_prhd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_lane       (rsp_lane),
   .rsp_position   (rsp_position),
   .rsp_symbol     (rsp_symbol),
   .rsp_end_of_run (rsp_end_of_run)
);

// ===== bench/piecewise_rolling_hash_digest_tb.sv =====
// Self-checking bench for the piecewise rolling hash digest engine.
`timescale 1ns / 100ps

module piecewise_rolling_hash_digest_tb;

   localparam int DIGEST_LEN   = prhd_pkg::DIGEST_LEN_DEFAULT;
   localparam int WINDOW_LEN   = prhd_pkg::WINDOW_LEN_DEFAULT;
   localparam int HASH_W       = prhd_pkg::HASH_W;
   localparam int BYTE_W       = prhd_pkg::BYTE_W;
   localparam int POS_W        = prhd_pkg::POS_W;
   localparam int SYM_W        = prhd_pkg::SYM_W;
   localparam int BS_W         = prhd_pkg::BS_W;
   localparam int CSR_IDX_W    = prhd_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W   = prhd_pkg::CSR_DATA_W;
   localparam int QUIET_CYCLES = 50;
   localparam int STALL_LIMIT  = 2000;
   localparam logic [8*64-1:0] B64_CHARS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic             lane;
      logic [POS_W-1:0] position;
      logic [SYM_W-1:0] symbol;
      logic             end_of_run;
   } digest_symbol_type;

   class symbol_tracker;
      logic [BS_W-1:0]   blk_size;
      logic              filter_on;
      logic              two_lanes;
      logic [HASH_W-1:0] win_sum;
      logic [HASH_W-1:0] wt_sum;
      logic [HASH_W-1:0] shift_acc;
      logic [HASH_W-1:0] roll_val;
      logic [BYTE_W-1:0] window [WINDOW_LEN];
      int unsigned       slot;
      logic [HASH_W-1:0] piece [2];
      logic [POS_W-1:0]  pos [2];
      logic [BYTE_W-1:0] last_byte;
      logic [1:0]        run_len;
      digest_symbol_type symbols_due [$];
      int unsigned       faults;

      function new();
         blk_size  = 31'd3;
         filter_on = 1'b1;
         two_lanes = 1'b0;
         faults    = 0;
         clear_msg();
      endfunction

      function void clear_msg();
         win_sum   = '0;
         wt_sum    = '0;
         shift_acc = '0;
         roll_val  = '0;
         slot      = 0;
         foreach (window[i]) window[i] = '0;
         piece[0]  = '0;
         piece[1]  = '0;
         pos[0]    = '0;
         pos[1]    = '0;
         last_byte = '0;
         run_len   = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            prhd_pkg::CSR_BLOCK_SIZE:    blk_size  = data[BS_W-1:0];
            prhd_pkg::CSR_REPEAT_FILTER: filter_on = data[0];
            prhd_pkg::CSR_DUAL_LANE:     two_lanes = data[0];
            default: ;
         endcase
      endfunction

      function bit is_separator(logic [BYTE_W-1:0] b);
         bit alnum;
         alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                 (b >= 8'h61 && b <= 8'h7A);
         return (b >= 8'h09 && b <= 8'h0D) || (b >= 8'h20 && b <= 8'h7E && !alnum);
      endfunction

      function logic [HASH_W-1:0] stir(logic [HASH_W-1:0] c, logic [HASH_W-1:0] h);
         logic [HASH_W-1:0] x;
         x = h ^ c;
         return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
      endfunction

      function void advance_window(logic [HASH_W-1:0] c);
         logic [HASH_W-1:0] leaving;
         if (slot >= WINDOW_LEN) slot = 0;
         // the byte leaving the window is widened again with its sign
         leaving = {{24{window[slot][7]}}, window[slot]};
         wt_sum = wt_sum - win_sum + 32'(WINDOW_LEN) * c;
         win_sum = win_sum + c - leaving;
         window[slot] = c[7:0];
         slot++;
         shift_acc = (shift_acc << 5) ^ c;
         roll_val = win_sum + wt_sum + shift_acc;
      endfunction

      function digest_symbol_type symbol_at(int ln);
         digest_symbol_type s;
         int idx;
         idx = int'(piece[ln][5:0]);
         s.lane       = ln[0];
         s.position   = pos[ln];
         s.symbol     = 7'(B64_CHARS[8*(63-idx) +: 8]);
         s.end_of_run = 1'b0;
         return s;
      endfunction

      function void take_byte(logic [BYTE_W-1:0] b, logic last);
         digest_symbol_type fresh [$];
         logic [HASH_W-1:0] c;
         logic [HASH_W-1:0] modulus;
         int                lanes;
         lanes = two_lanes ? 2 : 1;
         if (b == last_byte) begin
            if (run_len != 2'd3) run_len++;
         end else begin
            run_len = '0;
         end
         last_byte = b;
         if (!is_separator(b) && !(filter_on && run_len == 2'd3)) begin
            c = {{24{b[7]}}, b};
            advance_window(c);
            for (int ln = 0; ln < lanes; ln++) piece[ln] = stir(c, piece[ln]);
            for (int ln = 0; ln < lanes; ln++) begin
               modulus = (ln == 1) ? {blk_size, 1'b0} : {1'b0, blk_size};
               if (modulus != 0 && roll_val % modulus == modulus - 1) begin
                  fresh.push_back(symbol_at(ln));
                  // hold the last digest slot open; it keeps absorbing bytes
                  if (pos[ln] < DIGEST_LEN - 2) begin
                     piece[ln] = prhd_pkg::PIECE_RELOAD;
                     pos[ln]++;
                  end
               end
            end
         end
         if (last) begin
            if (roll_val != 0)
               for (int ln = 0; ln < lanes; ln++) fresh.push_back(symbol_at(ln));
            clear_msg();
         end
         if (fresh.size() != 0) fresh[fresh.size()-1].end_of_run = 1'b1;
         foreach (fresh[i]) symbols_due.push_back(fresh[i]);
      endfunction

      function int pending();
         return symbols_due.size();
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            faults++;
         end
      endfunction

      function void match_symbol(logic lane, logic [POS_W-1:0] position,
                                 logic [SYM_W-1:0] symbol, logic eor);
         digest_symbol_type want;
         if (symbols_due.size() == 0) begin
            $error("result with nothing expected: lane %0d position %0d symbol %0d",
                   lane, position, symbol);
            faults++;
            return;
         end
         want = symbols_due.pop_front();
         check_field("lane", want.lane, lane);
         check_field("position", want.position, position);
         check_field("symbol", want.symbol, symbol);
         check_field("end_of_run", want.end_of_run, eor);
      endfunction
   endclass

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_byte_in = '0;
   logic                  req_is_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic                  rsp_lane;
   logic [POS_W-1:0]      rsp_position;
   logic [SYM_W-1:0]      rsp_symbol;
   logic                  rsp_end_of_run;

   logic                  calm        = 1'b0;
   int                    hold_cycles = 0;
   int                    idle_cycles = 0;
   symbol_tracker         tracker;

   piecewise_rolling_hash_digest #(
      .DIGEST_LEN(DIGEST_LEN),
      .WINDOW_LEN(WINDOW_LEN)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_in    (req_byte_in),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_lane       (rsp_lane),
      .rsp_position   (rsp_position),
      .rsp_symbol     (rsp_symbol),
      .rsp_end_of_run (rsp_end_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: random stall bursts, none during reset or once calm is set
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ready   <= 1'b1;
         hold_cycles <= 0;
      end else if (hold_cycles != 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.match_symbol(rsp_lane, rsp_position, rsp_symbol, rsp_end_of_run);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("piecewise_rolling_hash_digest_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [BYTE_W-1:0] pick_byte();
      int unsigned sel;
      logic [BYTE_W-1:0] b;
      sel = $urandom_range(0, 19);
      if (sel < 13) begin
         case ($urandom_range(0, 2))
            0:       b = 8'h41 + 8'($urandom_range(0, 25));
            1:       b = 8'h61 + 8'($urandom_range(0, 25));
            default: b = 8'h30 + 8'($urandom_range(0, 9));
         endcase
      end else if (sel < 16) begin
         b = 8'($urandom_range(128, 255));
      end else if (sel < 18) begin
         b = 8'($urandom_range(0, 255));
      end else if (sel == 18) begin
         b = 8'($urandom_range(8'h21, 8'h2F));
      end else begin
         b = ($urandom_range(0, 1) == 0) ? 8'h20 : 8'($urandom_range(8'h09, 8'h0D));
      end
      return b;
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      req_is_last <= last;
      do @(posedge clock); while (!req_ready);
      tracker.take_byte(b, last);
   endtask

   task automatic send_run(input int count, input int last_every, input bit close_msg);
      logic [BYTE_W-1:0] b;
      logic last;
      int reps;
      reps = 0;
      b = '0;
      for (int i = 0; i < count; i++) begin
         if (reps == 0) begin
            b = pick_byte();
            reps = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 6) : 1;
         end
         reps--;
         last = (close_msg && i == count - 1) ||
                (last_every != 0 && $urandom_range(1, last_every) == 1);
         send_byte(b, last);
      end
   endtask

   // Always advance the clock first, then wait out every expected result.
   task automatic settle();
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.set_reg(idx, data);
   endtask

   task automatic set_config(input logic [BS_W-1:0] bs, input logic filt, input logic dual);
      req_valid <= 1'b0;
      settle();
      // a byte with no result may still be in flight
      repeat (QUIET_CYCLES) @(posedge clock);
      write_reg(prhd_pkg::CSR_BLOCK_SIZE, bs);
      write_reg(prhd_pkg::CSR_REPEAT_FILTER, CSR_DATA_W'(filt));
      write_reg(prhd_pkg::CSR_DUAL_LANE, CSR_DATA_W'(dual));
      csr_valid <= 1'b0;
   endtask

   // {is_last, byte}
   logic [8:0] opening [13] = '{
      9'h000, 9'h000, 9'h000, 9'h000, 9'h041, 9'h020, 9'h07E,
      9'h07F, 9'h080, 9'h0FF, 9'h07A, 9'h139, 9'h120
   };
   logic [8:0] no_trigger [6] = '{9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h051, 9'h101};

   initial begin
      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero-byte repeats, separators, signed bytes, empty flush
      foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);
      // zero block size with both lanes: flush only, repeats kept
      set_config('0, 1'b0, 1'b1);
      foreach (no_trigger[i]) send_byte(no_trigger[i][7:0], no_trigger[i][8]);

      // one long message drives lane 0 into its last digest slot
      set_config(31'd3, 1'b0, 1'b1);
      send_run(130, 0, 1'b0);
      req_valid <= 1'b0;
      settle();
      send_run(130, 0, 1'b1);

      set_config(31'd6, 1'b1, 1'b0);
      send_run(35, 20, 1'b1);
      set_config(31'h6000_0000, 1'b1, 1'b1);
      send_run(30, 6, 1'b1);
      set_config(31'h7FFF_FFFF, 1'b0, 1'b1);
      send_run(20, 5, 1'b1);
      set_config(31'd12, 1'b1, 1'b1);
      calm <= 1'b1;
      send_run(45, 25, 1'b1);

      req_valid <= 1'b0;
      settle();
      repeat (QUIET_CYCLES) @(posedge clock);
      if (tracker.pending() != 0) begin
         $error("%0d expected results never arrived", tracker.pending());
         tracker.faults++;
      end
      if (tracker.faults == 0) begin
         $display("piecewise_rolling_hash_digest_tb: clean");
      end else begin
         $display("piecewise_rolling_hash_digest_tb: errors");
      end
      $finish;
   end

endmodule
